>>> hw/rtl/lpg_pkg.sv
// LED pattern generator package: channel count, register map, mode codes and
// the level-to-duty table (level squared over 100). No dependencies.
`timescale 1ns / 1ps

package lpg_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CH_W         = $clog2(NUM_CHANNELS);
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 7;
	localparam int MODE_W       = 3;
	localparam int CODE_W       = 7;
	localparam int DUTY_W       = 7;
	localparam int COUNT_W      = 8;

	// register map: modes first, then codes
	localparam logic [CFG_IDX_W-1:0] REG_MODE_BASE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CODE_BASE = CFG_IDX_W'(NUM_CHANNELS);
	localparam logic [CFG_IDX_W-1:0] REG_END       = CFG_IDX_W'(2 * NUM_CHANNELS);

	localparam logic [DUTY_W-1:0] FULL_LEVEL = DUTY_W'(100);

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF     = 3'd0,
		MODE_ON      = 3'd1,
		MODE_BLINK   = 3'd2,
		MODE_BREATHE = 3'd3,
		MODE_ERROR   = 3'd4
	} mode_t;

	// duty = level * level / 100 for level 0..100
	localparam logic [DUTY_W-1:0] DUTY_LUT [101] = '{
		7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
		7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,
		7'd4,  7'd4,  7'd4,  7'd5,  7'd5,  7'd6,  7'd6,  7'd7,  7'd7,  7'd8,
		7'd9,  7'd9,  7'd10, 7'd10, 7'd11, 7'd12, 7'd12, 7'd13, 7'd14, 7'd15,
		7'd16, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24,
		7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34,
		7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd42, 7'd43, 7'd44, 7'd46, 7'd47,
		7'd49, 7'd50, 7'd51, 7'd53, 7'd54, 7'd56, 7'd57, 7'd59, 7'd60, 7'd62,
		7'd64, 7'd65, 7'd67, 7'd68, 7'd70, 7'd72, 7'd73, 7'd75, 7'd77, 7'd79,
		7'd81, 7'd82, 7'd84, 7'd86, 7'd88, 7'd90, 7'd92, 7'd94, 7'd96, 7'd98,
		7'd100
	};

endpackage

>>> hw/rtl/led_pattern_generator_unit.sv
// LED pattern generator top level: four LED channels with blink, breathe and
// error-code patterns. Depends on lpg_pkg.
`timescale 1ns / 1ps

// How to use the block
//   Tick channel (tick_valid / tick_stall / tick): each accepted beat is one
//   time step. tick = 1 advances every channel's pattern, tick = 0 leaves the
//   patterns where they are and only reports the current duties.
//   Duty channel (duty_valid / duty_stall / duty_led0..3): exactly one result
//   beat per accepted tick beat, in order, carrying the PWM compare value
//   (0..100) of each channel.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   index 0..3 writes the mode of channels 0..3, index 4..7 the error codes.
//   cfg_ready is always high. Write only while no tick is in flight.
//   A nonzero code locks both registers of its channel until reset.
// Data path: a tick beat lands in the input register, then moves on to update
//   the channel state and the result register. One beat per cycle is sustained
//   while the receiver does not stall.
// Reset clears all modes, codes, phase and period counters and duties to zero
//   and empties both registers. While the receiver stalls, the result holds;
//   an empty input register takes one further beat, and tick_stall is high
//   as long as the input register is full behind the waiting result.
module led_pattern_generator_unit #(
	parameter int PERIOD_LAST = 199
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// tick channel
	input  logic                           tick_valid,
	output logic                           tick_stall,
	input  logic                           tick,
	// duty channel
	output logic                           duty_valid,
	input  logic                           duty_stall,
	output logic [lpg_pkg::DUTY_W-1:0]     duty_led0,
	output logic [lpg_pkg::DUTY_W-1:0]     duty_led1,
	output logic [lpg_pkg::DUTY_W-1:0]     duty_led2,
	output logic [lpg_pkg::DUTY_W-1:0]     duty_led3,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NCH  = lpg_pkg::NUM_CHANNELS;
	localparam int PH_W = $clog2(PERIOD_LAST + 1);
	// level arithmetic must hold both the full period and the value 100
	localparam int LV_W = (PH_W + 1 > lpg_pkg::DUTY_W) ? PH_W + 1 : lpg_pkg::DUTY_W;
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(PERIOD_LAST);
	localparam logic [PH_W-1:0] PH_HALF = PH_W'((PERIOD_LAST + 1) / 2);
	localparam logic [LV_W-1:0] LV_PERIOD = LV_W'(PERIOD_LAST + 1);
	localparam logic [LV_W-1:0] LV_FULL   = LV_W'(100);

	// per-channel registers
	logic [lpg_pkg::MODE_W-1:0]  mode_q  [NCH];
	logic [lpg_pkg::CODE_W-1:0]  code_q  [NCH];
	logic [PH_W-1:0]             phase_q [NCH];
	logic [lpg_pkg::COUNT_W-1:0] count_q [NCH];
	logic [lpg_pkg::DUTY_W-1:0]  held_q  [NCH];

	// next-step values
	logic [PH_W-1:0]             phase_nxt [NCH];
	logic [lpg_pkg::COUNT_W-1:0] count_nxt [NCH];
	logic [lpg_pkg::DUTY_W-1:0]  held_nxt  [NCH];

	// input register and handshake
	logic tick_s1;
	logic valid_s1;
	logic duty_valid_q;
	logic advance;
	logic s1_move;
	logic tick_accept;

	// configuration decode
	logic                            cfg_we;
	logic                            cfg_is_mode;
	logic                            cfg_is_code;
	logic [lpg_pkg::CFG_IDX_W-1:0]   cfg_off;
	logic [lpg_pkg::CH_W-1:0]        cfg_ch;

	// Advance the input register when the result register is free or being taken.
	assign advance     = !duty_valid_q || !duty_stall;
	assign s1_move     = valid_s1 && advance;
	assign tick_stall  = valid_s1 && !advance;
	assign tick_accept = tick_valid && !tick_stall;
	assign duty_valid  = duty_valid_q;

	assign cfg_ready   = 1'b1;
	assign cfg_we      = cfg_valid && cfg_ready;
	assign cfg_is_mode = cfg_index < lpg_pkg::REG_CODE_BASE;
	assign cfg_is_code = !cfg_is_mode && (cfg_index < lpg_pkg::REG_END);
	// mode registers start at the base, codes follow one bank later
	assign cfg_off     = cfg_is_mode ? (cfg_index - lpg_pkg::REG_MODE_BASE)
	                                 : (cfg_index - lpg_pkg::REG_CODE_BASE);
	assign cfg_ch      = cfg_off[lpg_pkg::CH_W-1:0];

	// The held duty doubles as the result register: it only moves with s1_move.
	assign duty_led0 = held_q[0];
	assign duty_led1 = held_q[1];
	assign duty_led2 = held_q[2];
	assign duty_led3 = held_q[3];

	// One pattern step for every channel.
	always_comb begin
		logic [PH_W-1:0]             ph;
		logic [lpg_pkg::COUNT_W-1:0] cnt_inc;
		logic [LV_W-1:0]             lvl;
		logic [lpg_pkg::DUTY_W-1:0]  lvl_c;
		logic [lpg_pkg::DUTY_W-1:0]  blink;
		for (int c = 0; c < NCH; c++) begin
			ph = (phase_q[c] == PH_LAST) ? '0 : phase_q[c] + 1'b1;
			phase_nxt[c] = ph;

			// blink: full for the first half period
			blink = (ph < PH_HALF) ? lpg_pkg::FULL_LEVEL : '0;

			// breathe: triangle, clipped to full level
			lvl = (ph < PH_HALF) ? LV_W'(ph) : LV_PERIOD - LV_W'(ph);
			lvl_c = (lvl > LV_FULL) ? lpg_pkg::FULL_LEVEL : lvl[lpg_pkg::DUTY_W-1:0];

			// error: count whole periods, drop back once past the code
			cnt_inc = count_q[c];
			if (mode_q[c] == lpg_pkg::MODE_ERROR && ph == '0) begin
				cnt_inc = count_q[c] + 1'b1;
				if (cnt_inc > lpg_pkg::COUNT_W'(code_q[c]))
					cnt_inc = '0;
			end
			count_nxt[c] = cnt_inc;

			case (mode_q[c])
				lpg_pkg::MODE_ON:      held_nxt[c] = lpg_pkg::FULL_LEVEL;
				lpg_pkg::MODE_BLINK:   held_nxt[c] = blink;
				lpg_pkg::MODE_BREATHE: held_nxt[c] = lpg_pkg::DUTY_LUT[lvl_c];
				lpg_pkg::MODE_ERROR: begin
					// dark part of the sequence keeps the last duty
					if (cnt_inc >= lpg_pkg::COUNT_W'(code_q[c]))
						held_nxt[c] = held_q[c];
					else
						held_nxt[c] = blink;
				end
				default:               held_nxt[c] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1      <= 1'b0;
			valid_s1     <= 1'b0;
			duty_valid_q <= 1'b0;
			for (int c = 0; c < NCH; c++) begin
				mode_q[c]  <= '0;
				code_q[c]  <= '0;
				phase_q[c] <= '0;
				count_q[c] <= '0;
				held_q[c]  <= '0;
			end
		end else begin
			if (tick_accept) begin
				valid_s1 <= 1'b1;
				tick_s1  <= tick;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end

			if (s1_move)
				duty_valid_q <= 1'b1;
			else if (!duty_stall)
				duty_valid_q <= 1'b0;

			for (int c = 0; c < NCH; c++) begin
				if (s1_move) begin
					if (tick_s1) begin
						phase_q[c] <= phase_nxt[c];
						count_q[c] <= count_nxt[c];
						held_q[c]  <= held_nxt[c];
					end
				end else if (cfg_we && cfg_ch == lpg_pkg::CH_W'(c) && code_q[c] == '0) begin
					// a nonzero code locks the channel
					if (cfg_is_mode) begin
						mode_q[c] <= cfg_data[lpg_pkg::MODE_W-1:0];
					end else if (cfg_is_code) begin
						code_q[c]  <= cfg_data[lpg_pkg::CODE_W-1:0];
						phase_q[c] <= '0;
						count_q[c] <= '0;
					end
				end
			end
		end
	end

	// A result beat waits in the output register, so the input register
	// may hold at most one beat behind it.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> (valid_s1 && duty_valid_q))
		else $error("tick_stall raised without a beat behind a waiting result");

	for (genvar g = 0; g < NCH; g++) begin : g_chk
		a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
			held_q[g] <= lpg_pkg::FULL_LEVEL)
			else $error("duty above full level on channel %0d", g);

		a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
			phase_q[g] <= PH_LAST)
			else $error("phase past the end of the period on channel %0d", g);

		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[g] <= lpg_pkg::COUNT_W'(code_q[g]))
			else $error("period count ran past the code on channel %0d", g);

		a_lock_holds: assert property (@(posedge clk) disable iff (!arst_n)
			(code_q[g] != '0) |=> ($stable(code_q[g]) && $stable(mode_q[g])))
			else $error("locked channel %0d changed its settings", g);
	end

endmodule

>>> tb/lpg_duty_checker.sv
// Duty checker for the LED pattern generator: follows the register writes and
// tick beats, predicts every duty beat and compares it. Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_duty_checker #(
	parameter int PERIOD_LAST = 199
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_valid,
	input  logic                           tick_stall,
	input  logic                           tick,
	input  logic                           duty_valid,
	input  logic                           duty_stall,
	input  logic [lpg_pkg::DUTY_W-1:0]     duty_led0,
	input  logic [lpg_pkg::DUTY_W-1:0]     duty_led1,
	input  logic [lpg_pkg::DUTY_W-1:0]     duty_led2,
	input  logic [lpg_pkg::DUTY_W-1:0]     duty_led3,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             duty_pending,
	output int                             duties_seen
);
	import lpg_pkg::*;

	localparam int HALF_PERIOD = (PERIOD_LAST + 1) / 2;
	localparam int PERCENT     = 100;

	typedef logic [NUM_CHANNELS-1:0][DUTY_W-1:0] duty_set_t;

	logic [MODE_W-1:0]  chan_mode    [NUM_CHANNELS];
	logic [CODE_W-1:0]  chan_code    [NUM_CHANNELS];
	logic [COUNT_W-1:0] chan_phase   [NUM_CHANNELS];
	logic [COUNT_W-1:0] chan_periods [NUM_CHANNELS];
	logic [DUTY_W-1:0]  chan_duty    [NUM_CHANNELS];
	duty_set_t          duty_fifo    [$];

	function automatic logic [DUTY_W-1:0] level_duty(input int unsigned level);
		int unsigned lv;
		lv = level;
		if (lv > FULL_LEVEL)
			lv = FULL_LEVEL;
		return DUTY_W'(lv * lv / PERCENT);
	endfunction

	task automatic step_channel(input int c);
		int unsigned ph;
		if (chan_phase[c] < PERIOD_LAST)
			chan_phase[c] = chan_phase[c] + 1'b1;
		else
			chan_phase[c] = '0;
		ph = chan_phase[c];
		case (chan_mode[c])
			MODE_ERROR: begin
				if (ph == 0) begin
					chan_periods[c] = chan_periods[c] + 1'b1;
					if (chan_periods[c] > chan_code[c])
						chan_periods[c] = '0;
				end
				// past the code count the channel stays dark and keeps its duty
				if (chan_periods[c] < chan_code[c])
					chan_duty[c] = level_duty(ph < HALF_PERIOD ? int'(FULL_LEVEL) : 0);
			end
			MODE_ON:      chan_duty[c] = level_duty(FULL_LEVEL);
			MODE_BLINK:   chan_duty[c] = level_duty(ph < HALF_PERIOD ? int'(FULL_LEVEL) : 0);
			MODE_BREATHE: chan_duty[c] = level_duty(ph < HALF_PERIOD ? ph : PERIOD_LAST + 1 - ph);
			default:      chan_duty[c] = '0;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : predict
		int        c;
		duty_set_t want;
		duty_set_t got;
		if (!arst_n) begin
			for (c = 0; c < NUM_CHANNELS; c++) begin
				chan_mode[c]    = '0;
				chan_code[c]    = '0;
				chan_phase[c]   = '0;
				chan_periods[c] = '0;
				chan_duty[c]    = '0;
			end
			duty_fifo.delete();
			mismatches   = 0;
			duty_pending = 0;
			duties_seen  = 0;
		end else begin
			// retire the oldest expectation before taking this edge's tick
			if (duty_valid && !duty_stall) begin
				got = {duty_led3, duty_led2, duty_led1, duty_led0};
				duties_seen++;
				if (duty_fifo.size() == 0) begin
					mismatches++;
					$display("%0t: duty beat expected none, got %h", $time, got);
				end else begin
					want = duty_fifo.pop_front();
					for (c = 0; c < NUM_CHANNELS; c++) begin
						if (got[c] !== want[c]) begin
							$display("%0t: duty_led%0d expected %0d, got %0d",
								$time, c, want[c], got[c]);
							mismatches++;
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < REG_CODE_BASE) begin
					c = int'(cfg_index - REG_MODE_BASE);
					if (chan_code[c] == '0)
						chan_mode[c] = cfg_data[MODE_W-1:0];
				end else if (cfg_index < REG_END) begin
					c = int'(cfg_index - REG_CODE_BASE);
					if (chan_code[c] == '0) begin
						chan_code[c]    = cfg_data[CODE_W-1:0];
						chan_phase[c]   = '0;
						chan_periods[c] = '0;
					end
				end
			end
			if (tick_valid && !tick_stall) begin
				for (c = 0; c < NUM_CHANNELS; c++) begin
					if (tick)
						step_channel(c);
					want[c] = chan_duty[c];
				end
				duty_fifo.push_back(want);
			end
			duty_pending = duty_fifo.size();
		end
	end

endmodule

>>> tb/tb_led_pattern_generator_unit.sv
// Testbench top for the LED pattern generator: drives tick beats, register
// writes and receiver stalls. Depends on lpg_pkg, lpg_duty_checker and the DUT.
`timescale 1ns / 1ps

module tb_led_pattern_generator_unit;
	import lpg_pkg::*;

	localparam int PERIOD_LAST   = 199;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD     = 80;
	localparam int CYCLE_LIMIT   = 300000;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  tick_valid = 1'b0;
	logic                  tick_stall;
	logic                  tick       = 1'b0;
	logic                  duty_valid;
	logic                  duty_stall = 1'b0;
	logic [DUTY_W-1:0]     duty_led0, duty_led1, duty_led2, duty_led3;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	int mismatches, duty_pending, duties_seen;
	int beats_sent   = 0;
	int idle_ticks   = 0;
	int reg_writes   = 0;
	int cycle_count  = 0;
	bit hold_request = 1'b0;
	bit calm         = 1'b0;

	led_pattern_generator_unit #(.PERIOD_LAST(PERIOD_LAST)) dut (
		.clk(clk), .arst_n(arst_n),
		.tick_valid(tick_valid), .tick_stall(tick_stall), .tick(tick),
		.duty_valid(duty_valid), .duty_stall(duty_stall),
		.duty_led0(duty_led0), .duty_led1(duty_led1),
		.duty_led2(duty_led2), .duty_led3(duty_led3),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lpg_duty_checker #(.PERIOD_LAST(PERIOD_LAST)) duty_watch (
		.clk(clk), .arst_n(arst_n),
		.tick_valid(tick_valid), .tick_stall(tick_stall), .tick(tick),
		.duty_valid(duty_valid), .duty_stall(duty_stall),
		.duty_led0(duty_led0), .duty_led1(duty_led1),
		.duty_led2(duty_led2), .duty_led3(duty_led3),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .duty_pending(duty_pending), .duties_seen(duties_seen)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: end the run if the beats stop flowing.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d duty beats outstanding",
				cycle_count, duty_pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: stall in random bursts, hold off for one long stretch on request,
	// and drop all stalling once the run goes calm.
	initial begin : receiver
		int run;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				duty_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (calm) begin
				duty_stall <= 1'b0;
			end else begin
				run = $urandom_range(1, 19);
				duty_stall <= ($urandom_range(0, 2) == 0);
				repeat (run - 1) @(negedge clk);
			end
		end
	end

	// Offer one tick beat, optionally after an idle burst; hold it until taken.
	// Enter and leave at a falling edge with tick_valid still high.
	task automatic send_beat(input logic level, input int gap_odds);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		tick_valid <= 1'b1;
		tick       <= level;
		do @(posedge clk); while (tick_stall);
		@(negedge clk);
		beats_sent++;
		if (!level)
			idle_ticks++;
	endtask

	// Random ticks, roughly one in ten standing still.
	task automatic run_ticks(input int count, input int gap_odds);
		for (int n = 0; n < count; n++)
			send_beat($urandom_range(0, 9) != 0, gap_odds);
		tick_valid <= 1'b0;
	endtask

	// Write one register; cfg_valid stays high for a following write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		reg_writes++;
	endtask

	// Wait for every expected duty beat, then let the pipeline go quiet.
	task automatic settle();
		while (duty_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int gap_odds [4] = '{4, 6, 0, 3};
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: every channel off, standing and moving ticks.
		send_beat(1'b0, 0);
		send_beat(1'b1, 0);
		send_beat(1'b1, 0);
		send_beat(1'b0, 0);
		tick_valid <= 1'b0;
		settle();

		// One channel per pattern, channel 3 on an unused mode with all data
		// bits set; writes past the register map must change nothing, and a
		// zero code only clears the counters without locking.
		write_reg(REG_MODE_BASE + CFG_IDX_W'(0), CFG_DATA_W'(MODE_ON));
		write_reg(REG_MODE_BASE + CFG_IDX_W'(1), CFG_DATA_W'(MODE_BLINK));
		write_reg(REG_MODE_BASE + CFG_IDX_W'(2), CFG_DATA_W'(MODE_BREATHE));
		write_reg(REG_MODE_BASE + CFG_IDX_W'(3), '1);
		write_reg(REG_END, '1);
		write_reg('1, '0);
		write_reg(REG_CODE_BASE + CFG_IDX_W'(3), '0);
		cfg_valid <= 1'b0;
		for (int n = 0; n < 21; n++)
			send_beat(n % 9 != 4, 0);
		tick_valid <= 1'b0;

		// Unlocked phases: random modes with random upper data bits, one channel
		// in error mode with a zero code so it keeps its last duty, occasional
		// counter clears and out-of-range writes.
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (c == ph)
					write_reg(REG_MODE_BASE + CFG_IDX_W'(c),
						{(CFG_DATA_W - MODE_W)'($urandom), MODE_ERROR});
				else if ($urandom_range(0, 3) != 0)
					write_reg(REG_MODE_BASE + CFG_IDX_W'(c), CFG_DATA_W'($urandom_range(0, 127)));
				if ($urandom_range(0, 2) == 0)
					write_reg(REG_CODE_BASE + CFG_IDX_W'(c), '0);
			end
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_END, (1 << CFG_IDX_W) - 1)),
					CFG_DATA_W'($urandom_range(0, 127)));
			cfg_valid <= 1'b0;
			// hold the receiver off while the sender keeps pushing
			if (ph == 2)
				hold_request = 1'b1;
			run_ticks(85, gap_odds[ph]);
		end

		// Lock every channel with a nonzero code, the largest among them, then
		// try to change the locked settings: those writes must be ignored.
		settle();
		write_reg(REG_MODE_BASE + CFG_IDX_W'(0), CFG_DATA_W'(MODE_ERROR));
		write_reg(REG_CODE_BASE + CFG_IDX_W'(0), CFG_DATA_W'(2));
		write_reg(REG_MODE_BASE + CFG_IDX_W'(1), CFG_DATA_W'(MODE_ERROR));
		write_reg(REG_CODE_BASE + CFG_IDX_W'(1), '1);
		write_reg(REG_MODE_BASE + CFG_IDX_W'(2), CFG_DATA_W'(MODE_BREATHE));
		write_reg(REG_CODE_BASE + CFG_IDX_W'(2), CFG_DATA_W'(1));
		write_reg(REG_MODE_BASE + CFG_IDX_W'(3), CFG_DATA_W'(MODE_ERROR));
		write_reg(REG_CODE_BASE + CFG_IDX_W'(3), CFG_DATA_W'(1));
		write_reg(REG_MODE_BASE + CFG_IDX_W'(0), CFG_DATA_W'(MODE_OFF));
		write_reg(REG_CODE_BASE + CFG_IDX_W'(0), '0);
		write_reg(REG_MODE_BASE + CFG_IDX_W'(2), CFG_DATA_W'(MODE_ON));
		write_reg(REG_CODE_BASE + CFG_IDX_W'(3), CFG_DATA_W'(5));
		cfg_valid <= 1'b0;
		run_ticks(300, 4);

		// Last stretch at full rate on both sides.
		calm = 1'b1;
		run_ticks(60, 0);

		while (duty_pending != 0)
			@(negedge clk);
		repeat (2 * SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d tick beats (%0d standing still), %0d register writes",
			beats_sent, idle_ticks, reg_writes);
		$display("Checked %0d duty beats across off, on, blink, breathe, error and lock cases",
			duties_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
